// File: src/pida_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pida_pkg
// Shared types and constants for the positional insert/delete word list.
// ----------------------------------------------------------------------------
package pida_pkg;

   localparam int CAPACITY = 64;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int COUNT_W  = 7;
   localparam int WORD_W   = 32;
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 2;

   localparam logic [COUNT_W-1:0] CAPACITY_COUNT = COUNT_W'(CAPACITY);

   localparam logic [CMD_W-1:0] CMD_DISPLAY = 2'd0;
   localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DELETE  = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK     = 2'd0,
      STATUS_BADPOS = 2'd1,
      STATUS_FULL   = 2'd2,
      STATUS_EMPTY  = 2'd3
   } status_type;

   // Control from the sequencer to the word store
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [WORD_W-1:0] wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } mem_ctl_type;

endpackage
`default_nettype wire

// File: src/pida_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pida_req_if
// Command channel: valid/ready handshake with command, position and element.
// ----------------------------------------------------------------------------
interface pida_req_if;
   logic                                   valid;
   logic                                   ready;
   logic        [pida_pkg::CMD_W-1:0]      command;
   logic        [pida_pkg::COUNT_W-1:0]    position;
   logic signed [pida_pkg::WORD_W-1:0]     element;

   modport source (output valid, output command, output position, output element,
                   input ready);
   modport sink   (input valid, input command, input position, input element,
                   output ready);
endinterface
`default_nettype wire

// File: src/pida_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pida_rsp_if
// Result channel: valid/ready handshake with value, status, total and last.
// ----------------------------------------------------------------------------
interface pida_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [pida_pkg::WORD_W-1:0]     value;
   logic        [pida_pkg::STATUS_W-1:0]   status;
   logic        [pida_pkg::COUNT_W-1:0]    entry_total;
   logic                                   last;

   modport source (output valid, output value, output status, output entry_total,
                   output last, input ready);
   modport sink   (input valid, input value, input status, input entry_total,
                   input last, output ready);
endinterface
`default_nettype wire

// File: src/pida_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pida_store
// Word store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pida_store (
   input  wire                                  clock,
   input  wire pida_pkg::mem_ctl_type           mem_ctl,
   output logic [pida_pkg::WORD_W-1:0]          rd_data_ff
);

   logic [pida_pkg::WORD_W-1:0] mem_ff [pida_pkg::CAPACITY];

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         mem_ff[mem_ctl.wr_addr] <= mem_ctl.wr_data;
      end
   end

   // hold read data when no read is issued
   always_ff @(posedge clock) begin
      if (mem_ctl.rd_en) begin
         rd_data_ff <= mem_ff[mem_ctl.rd_addr];
      end
   end

endmodule
`default_nettype wire

// File: src/positional_insert_delete_array_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// positional_insert_delete_array_top
// Ordered list of up to CAPACITY signed words with insert, delete and display.
// ----------------------------------------------------------------------------
//
//  channel   | dir | payload                                  | notes
//  ----------+-----+------------------------------------------+---------------------------
//  req_ch    | in  | command, position, element               | one command per transaction
//  rsp_ch    | out | value, status, entry_total, last         | 0..CAPACITY per command
//
//  Sequencing: a sequencer moves one word per read/write pair through the store
//  (one read, one write port). Insert at p moves each word at p or above up,
//  delete at p moves each word above p down, display reads and emits each word;
//  a rejected command or an empty-list display goes to its result, unused code to idle.
//  Reset: synchronous, active high; clear count, sequencer, result valid; not the store.
//  Stalls: req_ch.ready is high only in idle; a stalled result holds the result or emit step.
//
module positional_insert_delete_array_top (
   input  wire  clock,
   input  wire  reset,
   pida_req_if.sink   req_ch,
   pida_rsp_if.source rsp_ch
);

   typedef enum logic [9:0] {
      ST_IDLE      = 10'b00_0000_0001,
      ST_RESULT    = 10'b00_0000_0010,
      ST_DISP_RD   = 10'b00_0000_0100,
      ST_DISP_EMIT = 10'b00_0000_1000,
      ST_INS_RD    = 10'b00_0001_0000,
      ST_INS_WR    = 10'b00_0010_0000,
      ST_DEL_RD0   = 10'b00_0100_0000,
      ST_DEL_TAKE  = 10'b00_1000_0000,
      ST_DEL_RD    = 10'b01_0000_0000,
      ST_DEL_WR    = 10'b10_0000_0000
   } state_type;

   state_type                          state_ff, state_in;
   logic [pida_pkg::COUNT_W-1:0]       count_ff, count_in;
   logic [pida_pkg::COUNT_W-1:0]       idx_ff, idx_in;
   logic [pida_pkg::COUNT_W-1:0]       pos_ff, pos_in;
   logic [pida_pkg::WORD_W-1:0]        elem_ff, elem_in;
   logic [pida_pkg::WORD_W-1:0]        res_value_ff, res_value_in;
   pida_pkg::status_type               res_status_ff, res_status_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic [pida_pkg::WORD_W-1:0]        rsp_value_ff, rsp_value_in;
   pida_pkg::status_type               rsp_status_ff, rsp_status_in;
   logic [pida_pkg::COUNT_W-1:0]       rsp_total_ff, rsp_total_in;
   logic                               rsp_last_ff, rsp_last_in;

   pida_pkg::mem_ctl_type              mem_ctl;
   logic [pida_pkg::WORD_W-1:0]        rd_data;

   logic                               req_fire;
   logic                               out_free;
   logic [pida_pkg::COUNT_W-1:0]       idx_inc;
   logic [pida_pkg::COUNT_W-1:0]       idx_dec;

   pida_store u_store (
      .clock      (clock),
      .mem_ctl    (mem_ctl),
      .rd_data_ff (rd_data)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   // output register may take a new transaction when empty or draining now
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   // shared index step unit
   assign idx_inc = idx_ff + pida_pkg::COUNT_W'(1);
   assign idx_dec = idx_ff - pida_pkg::COUNT_W'(1);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      elem_in       = elem_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_last_in   = rsp_last_ff;
      mem_ctl       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               pos_in        = req_ch.position;
               elem_in       = req_ch.element;
               res_value_in  = '0;
               priority if (req_ch.command == pida_pkg::CMD_DISPLAY) begin
                  if (count_ff == '0) begin
                     res_status_in = pida_pkg::STATUS_EMPTY;
                     state_in      = ST_RESULT;
                  end else begin
                     idx_in   = '0;
                     state_in = ST_DISP_RD;
                  end
               end else if (req_ch.command == pida_pkg::CMD_INSERT) begin
                  priority if (req_ch.position > count_ff) begin
                     res_status_in = pida_pkg::STATUS_BADPOS;
                     state_in      = ST_RESULT;
                  end else if (count_ff == pida_pkg::CAPACITY_COUNT) begin
                     res_status_in = pida_pkg::STATUS_FULL;
                     state_in      = ST_RESULT;
                  end else begin
                     idx_in   = count_ff;
                     state_in = ST_INS_RD;
                  end
               end else if (req_ch.command == pida_pkg::CMD_DELETE) begin
                  if (req_ch.position >= count_ff) begin
                     res_status_in = pida_pkg::STATUS_BADPOS;
                     state_in      = ST_RESULT;
                  end else begin
                     idx_in   = req_ch.position;
                     state_in = ST_DEL_RD0;
                  end
               end else begin
                  // unused command: drop it without a result
                  state_in = ST_IDLE;
               end
            end
         end

         ST_RESULT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = res_value_ff;
               rsp_status_in = res_status_ff;
               rsp_total_in  = count_ff;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end

         ST_DISP_RD: begin
            mem_ctl.rd_en   = 1'b1;
            mem_ctl.rd_addr = idx_ff[pida_pkg::ADDR_W-1:0];
            state_in        = ST_DISP_EMIT;
         end

         ST_DISP_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = rd_data;
               rsp_status_in = pida_pkg::STATUS_OK;
               rsp_total_in  = count_ff;
               rsp_last_in   = (idx_inc == count_ff);
               idx_in        = idx_inc;
               state_in      = (idx_inc == count_ff) ? ST_IDLE : ST_DISP_RD;
            end
         end

         ST_INS_RD: begin
            if (idx_ff == pos_ff) begin
               mem_ctl.wr_en   = 1'b1;
               mem_ctl.wr_addr = pos_ff[pida_pkg::ADDR_W-1:0];
               mem_ctl.wr_data = elem_ff;
               count_in        = count_ff + pida_pkg::COUNT_W'(1);
               res_value_in    = elem_ff;
               res_status_in   = pida_pkg::STATUS_OK;
               state_in        = ST_RESULT;
            end else begin
               mem_ctl.rd_en   = 1'b1;
               mem_ctl.rd_addr = idx_dec[pida_pkg::ADDR_W-1:0];
               state_in        = ST_INS_WR;
            end
         end

         ST_INS_WR: begin
            // move the word one place up
            mem_ctl.wr_en   = 1'b1;
            mem_ctl.wr_addr = idx_ff[pida_pkg::ADDR_W-1:0];
            mem_ctl.wr_data = rd_data;
            idx_in          = idx_dec;
            state_in        = ST_INS_RD;
         end

         ST_DEL_RD0: begin
            mem_ctl.rd_en   = 1'b1;
            mem_ctl.rd_addr = idx_ff[pida_pkg::ADDR_W-1:0];
            state_in        = ST_DEL_TAKE;
         end

         ST_DEL_TAKE: begin
            res_value_in = rd_data;
            state_in     = ST_DEL_RD;
         end

         ST_DEL_RD: begin
            if (idx_inc >= count_ff) begin
               count_in      = count_ff - pida_pkg::COUNT_W'(1);
               res_status_in = pida_pkg::STATUS_OK;
               state_in      = ST_RESULT;
            end else begin
               mem_ctl.rd_en   = 1'b1;
               mem_ctl.rd_addr = idx_inc[pida_pkg::ADDR_W-1:0];
               state_in        = ST_DEL_WR;
            end
         end

         ST_DEL_WR: begin
            // move the word one place down
            mem_ctl.wr_en   = 1'b1;
            mem_ctl.wr_addr = idx_ff[pida_pkg::ADDR_W-1:0];
            mem_ctl.wr_data = rd_data;
            idx_in          = idx_inc;
            state_in        = ST_DEL_RD;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      elem_ff       <= elem_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.value       = rsp_value_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.entry_total = rsp_total_ff;
   assign rsp_ch.last        = rsp_last_ff;

   // the list never grows past its capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= pida_pkg::CAPACITY_COUNT)
      else $error("entry count exceeds capacity");

   // the count moves by at most one per cycle
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (count_ff == $past(count_ff)
                         || count_ff == $past(count_ff) + pida_pkg::COUNT_W'(1)
                         || count_ff == $past(count_ff) - pida_pkg::COUNT_W'(1)))
      else $error("entry count jumped");

   // only a display emits transactions without last, and those are ok
   a_nonlast_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> (rsp_status_ff == pida_pkg::STATUS_OK))
      else $error("non-final result with error status");

   // an error result carries a zero value
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != pida_pkg::STATUS_OK) |-> (rsp_value_ff == '0))
      else $error("error result with nonzero value");

endmodule
`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the positional insert/delete word list. A scoreboard
// class mirrors the list, predicts every result transaction of each accepted
// command and compares the result channel against it field by field.
// ----------------------------------------------------------------------------

typedef struct {
   logic signed [pida_pkg::WORD_W-1:0] value;
   pida_pkg::status_type               status;
   logic [pida_pkg::COUNT_W-1:0]       total;
   logic                               last;
} list_result_type;

class list_scoreboard;
   logic signed [pida_pkg::WORD_W-1:0] stored_words[$];
   list_result_type                    results_due[$];
   int unsigned                        fault_count;
   int unsigned                        results_seen;

   function void push_result(logic signed [pida_pkg::WORD_W-1:0] value,
                             pida_pkg::status_type status, logic last);
      list_result_type r;
      r.value  = value;
      r.status = status;
      r.total  = pida_pkg::COUNT_W'(stored_words.size());
      r.last   = last;
      results_due.push_back(r);
   endfunction

   // Apply an accepted command to the mirror list and queue its results.
   function void note_command(logic [pida_pkg::CMD_W-1:0] cmd,
                              logic [pida_pkg::COUNT_W-1:0] pos,
                              logic signed [pida_pkg::WORD_W-1:0] elem);
      int unsigned                        count;
      logic signed [pida_pkg::WORD_W-1:0] removed;
      count = stored_words.size();
      case (cmd)
         pida_pkg::CMD_DISPLAY: begin
            if (count == 0)
               push_result('0, pida_pkg::STATUS_EMPTY, 1'b1);
            else
               foreach (stored_words[i])
                  push_result(stored_words[i], pida_pkg::STATUS_OK, i == count - 1);
         end
         pida_pkg::CMD_INSERT: begin
            if (pos > count)
               push_result('0, pida_pkg::STATUS_BADPOS, 1'b1);
            else if (count >= pida_pkg::CAPACITY)
               push_result('0, pida_pkg::STATUS_FULL, 1'b1);
            else begin
               stored_words.insert(int'(pos), elem);
               push_result(elem, pida_pkg::STATUS_OK, 1'b1);
            end
         end
         pida_pkg::CMD_DELETE: begin
            if (pos >= count)
               push_result('0, pida_pkg::STATUS_BADPOS, 1'b1);
            else begin
               removed = stored_words[pos];
               stored_words.delete(int'(pos));
               push_result(removed, pida_pkg::STATUS_OK, 1'b1);
            end
         end
         default: ;
      endcase
   endfunction

   function void flag(string msg);
      fault_count++;
      if (fault_count <= 10)
         $display("MISMATCH %s", msg);
   endfunction

   function void check_result(logic signed [pida_pkg::WORD_W-1:0] value,
                              logic [pida_pkg::STATUS_W-1:0] status,
                              logic [pida_pkg::COUNT_W-1:0] total, logic last);
      list_result_type due;
      results_seen++;
      if (results_due.size() == 0) begin
         flag($sformatf("result %0d arrived with nothing due: value %0d status %0d total %0d",
                        results_seen, value, status, total));
         return;
      end
      due = results_due.pop_front();
      if (value !== due.value)
         flag($sformatf("result %0d value: expected %0d, got %0d",
                        results_seen, due.value, value));
      if (status !== due.status)
         flag($sformatf("result %0d status: expected %s, got %0d",
                        results_seen, due.status.name(), status));
      if (total !== due.total)
         flag($sformatf("result %0d entry_total: expected %0d, got %0d",
                        results_seen, due.total, total));
      if (last !== due.last)
         flag($sformatf("result %0d last: expected %0b, got %0b",
                        results_seen, due.last, last));
   endfunction
endclass

module tb_top;

   // Command code that the block ignores: no result transaction follows.
   localparam logic [pida_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int unsigned CYCLE_LIMIT  = 2_000_000;
   localparam int unsigned SETTLE_WAIT  = 2 * pida_pkg::CAPACITY + 80;
   localparam int unsigned RANDOM_GOAL  = 330;

   logic clock;
   logic reset;

   pida_req_if req_if ();
   pida_rsp_if rsp_if ();

   positional_insert_delete_array_top u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   list_scoreboard board = new();

   int unsigned cycle_count = 0;
   int unsigned commands_sent = 0;
   int unsigned burst_left = 1;
   bit          req_up = 1'b0;

   initial clock = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 0;
   end

   // Watchdog: a hung handshake or a missing result ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   // Result monitor: every accepted result transaction goes to the scoreboard.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         board.check_result(rsp_if.value, rsp_if.status, rsp_if.entry_total, rsp_if.last);
   end

   // Receiver: ready follows a pattern that is chosen anew after each random span,
   // from always ready through random stalls to long stall stretches.
   initial begin : rsp_pacer
      int unsigned mode;
      int unsigned span;
      int unsigned k;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(16, 64);
         for (k = 0; k < span; k++) begin
            case (mode)
               0:       rsp_if.ready <= 1'b1;
               1:       rsp_if.ready <= 1'($urandom_range(0, 1));
               2:       rsp_if.ready <= (k % 4 == 3);
               default: rsp_if.ready <= (k % 10 < 3);
            endcase
            @(posedge clock);
         end
      end
   end

   // Drop valid (if up) and then idle for the requested span.
   task automatic idle_cycles(int unsigned n);
      if (req_up) begin
         req_if.valid <= 1'b0;
         req_up = 1'b0;
      end
      repeat (n) @(posedge clock);
   endtask

   // Present one command and hold it until the block takes it; valid stays
   // high within a burst so a following command is presented without a gap.
   task automatic send_command(logic [pida_pkg::CMD_W-1:0] cmd,
                               logic [pida_pkg::COUNT_W-1:0] pos,
                               logic signed [pida_pkg::WORD_W-1:0] elem);
      req_if.valid    <= 1'b1;
      req_if.command  <= cmd;
      req_if.position <= pos;
      req_if.element  <= elem;
      req_up = 1'b1;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      board.note_command(cmd, pos, elem);
      if (cmd != CMD_UNUSED)
         commands_sent++;
      // End of a burst: idle a random gap, then start a new burst.
      burst_left--;
      if (burst_left == 0) begin
         idle_cycles($urandom_range(1, 12));
         burst_left = $urandom_range(1, 24);
      end
   endtask

   // Hold off the sender until every predicted result has been seen.
   task automatic wait_results_done();
      idle_cycles(0);
      while (board.results_due.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [pida_pkg::WORD_W-1:0] pick_word();
      case ($urandom_range(0, 15))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2:       return '0;
         3:       return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   // Legal position for insert (0..count) or delete (0..count-1), with the
   // ends of the range favored. An empty list has no legal delete position.
   function automatic logic [pida_pkg::COUNT_W-1:0] pick_position(bit for_insert);
      int unsigned top;
      int unsigned roll;
      top  = board.stored_words.size();
      roll = $urandom_range(0, 9);
      if (!for_insert) begin
         if (top == 0)
            return pida_pkg::COUNT_W'($urandom_range(0, 127));
         top = top - 1;
      end
      if (roll == 0)
         return '0;
      if (roll == 1)
         return pida_pkg::COUNT_W'(top);
      return pida_pkg::COUNT_W'($urandom_range(0, top));
   endfunction

   // Any command code, any position, any word.
   task automatic send_noise();
      send_command(pida_pkg::CMD_W'($urandom_range(0, 3)),
                   pida_pkg::COUNT_W'($urandom_range(0, 127)), pick_word());
   endtask

   initial begin : stimulus
      int unsigned roll;
      int unsigned i;

      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.command   <= pida_pkg::CMD_DISPLAY;
      req_if.position  <= '0;
      req_if.element   <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty-list cases, appends, ends of the position range,
      // extreme words, the ignored command code.
      send_command(pida_pkg::CMD_DISPLAY, 7'd0,   32'sd0);
      send_command(pida_pkg::CMD_DELETE,  7'd0,   32'sd0);
      send_command(pida_pkg::CMD_INSERT,  7'd1,   32'sd5);
      send_command(pida_pkg::CMD_INSERT,  7'd0,   32'sh7FFF_FFFF);
      send_command(pida_pkg::CMD_INSERT,  7'd1,   32'sh8000_0000);
      send_command(pida_pkg::CMD_INSERT,  7'd0,   32'sd0);
      send_command(pida_pkg::CMD_INSERT,  7'd1,   -32'sd1);
      send_command(pida_pkg::CMD_INSERT,  7'd127, 32'sd9);
      send_command(pida_pkg::CMD_INSERT,  7'd5,   32'sd9);
      send_command(pida_pkg::CMD_INSERT,  7'd4,   32'sh5555_5555);
      send_command(pida_pkg::CMD_DISPLAY, 7'd0,   32'sd0);
      send_command(pida_pkg::CMD_DELETE,  7'd5,   32'sd0);
      send_command(pida_pkg::CMD_DELETE,  7'd127, -32'sd1);
      send_command(pida_pkg::CMD_DELETE,  7'd4,   32'sd0);
      send_command(pida_pkg::CMD_DELETE,  7'd0,   32'sd0);
      send_command(pida_pkg::CMD_DELETE,  7'd1,   32'sd0);
      send_command(CMD_UNUSED,            7'd127, -32'sd1);
      send_command(pida_pkg::CMD_DISPLAY, 7'd0,   32'sd0);
      send_command(pida_pkg::CMD_DELETE,  7'd0,   32'sd0);
      send_command(pida_pkg::CMD_DELETE,  7'd0,   32'sd0);
      send_command(pida_pkg::CMD_DELETE,  7'd0,   32'sd0);
      send_command(pida_pkg::CMD_DISPLAY, 7'd0,   32'sd0);
      send_command(pida_pkg::CMD_INSERT,  7'd0,   32'shAAAA_AAAA);

      // Pause the sender until the block has answered everything so far.
      wait_results_done();
      commands_sent = 0;

      // Fill phase: grow the list to capacity, mostly with legal inserts.
      while (board.stored_words.size() < pida_pkg::CAPACITY) begin
         if ($urandom_range(0, 9) == 0)
            send_noise();
         else
            send_command(pida_pkg::CMD_INSERT, pick_position(1'b1), pick_word());
      end
      // Full list: legal positions report full, a wild one a bad position.
      for (i = 0; i < 3; i++)
         send_command(pida_pkg::CMD_INSERT, pick_position(1'b1), pick_word());
      send_command(pida_pkg::CMD_INSERT,
                   pida_pkg::COUNT_W'($urandom_range(pida_pkg::CAPACITY + 1, 127)),
                   pick_word());
      wait_results_done();
      send_command(pida_pkg::CMD_DISPLAY, pida_pkg::COUNT_W'($urandom_range(0, 127)),
                   pick_word());

      // Drain phase: shrink back to empty, mostly with legal deletes.
      while (board.stored_words.size() > 0) begin
         roll = $urandom_range(0, 99);
         if (roll < 85)
            send_command(pida_pkg::CMD_DELETE, pick_position(1'b0), pick_word());
         else if (roll < 92)
            send_command(pida_pkg::CMD_INSERT, pick_position(1'b1), pick_word());
         else if (roll < 95)
            send_command(pida_pkg::CMD_DISPLAY,
                         pida_pkg::COUNT_W'($urandom_range(0, 127)), pick_word());
         else
            send_noise();
      end

      // Mixed traffic: a random walk of list length with occasional dumps.
      while (commands_sent < RANDOM_GOAL) begin
         roll = $urandom_range(0, 99);
         if (roll < 40)
            send_command(pida_pkg::CMD_INSERT, pick_position(1'b1), pick_word());
         else if (roll < 75)
            send_command(pida_pkg::CMD_DELETE, pick_position(1'b0), pick_word());
         else if (roll < 82)
            send_command(pida_pkg::CMD_DISPLAY,
                         pida_pkg::COUNT_W'($urandom_range(0, 127)), pick_word());
         else
            send_noise();
      end

      // Wind down: wait out every result, then let the sequencer settle so a
      // stray extra transaction would still be caught.
      wait_results_done();
      repeat (SETTLE_WAIT) @(posedge clock);
      if (board.fault_count == 0 && board.results_due.size() == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule

// File: files.f
src/pida_pkg.sv
src/pida_req_if.sv
src/pida_rsp_if.sv
src/pida_store.sv
src/positional_insert_delete_array_top.sv
verif/tb_top.sv
